[design/irc_line_tokenizer_defines.svh]
// Assertion macros shared by the tokenizer modules.
// Included by files that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef IRC_LINE_TOKENIZER_DEFINES_SVH
`define IRC_LINE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/irc_pkg.sv]
// Shared types, constants and the tokenizer step function for the IRC line tokenizer.
// No dependencies; imported by irc_front, irc_back, irc_line_tokenizer and its testbench.
`timescale 1ns / 1ps

package irc_pkg;

  localparam int IRC_WS_DEPTH = 16;
  localparam int IRC_QDEPTH   = 4;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [2:0] KIND_PREFIX   = 3'd0;
  localparam logic [2:0] KIND_COMMAND  = 3'd1;
  localparam logic [2:0] KIND_PARAM    = 3'd2;
  localparam logic [2:0] KIND_TRAILING = 3'd3;
  localparam logic [2:0] KIND_STATUS   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NO_CMD    = 2'd2;
  localparam logic [1:0] ST_WS_OVFL   = 2'd3;

  localparam logic [3:0] PARAM_MAX = 4'd15;

  typedef enum logic [2:0] {
    PH_LEAD      = 3'd0,
    PH_PREFIX    = 3'd1,
    PH_PRE_GAP   = 3'd2,
    PH_COMMAND   = 3'd3,
    PH_PARAM_GAP = 3'd4,
    PH_PARAM     = 3'd5,
    PH_TRAILING  = 3'd6
  } irc_phase_t;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_RD     = 3'd1,
    BK_REPLAY = 3'd2,
    BK_BYTE   = 3'd3,
    BK_STATUS = 3'd4
  } bk_state_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
  } irc_in_t;

  typedef struct packed {
    logic [2:0] field_kind;
    logic [7:0] out_byte;
    logic       field_start;
    logic [3:0] param_number;
    logic [1:0] line_status;
    logic       prefix_seen;
    logic       trailing_seen;
    logic [3:0] param_total;
    logic       last_of_line;
  } irc_out_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
    logic       is_ws;
  } irc_q_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic [7:0] obyte;
    logic       start;
    logic [3:0] pnum;
    irc_phase_t phase;
    logic       field_open;
    logic [3:0] param_cnt;
    logic       set_prefix;
    logic       set_trailing;
  } tok_res_t;

  function automatic logic irc_is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  // One tokenizer step on a single byte.
  function automatic tok_res_t irc_tokenize(input irc_phase_t phase,
                                            input logic [7:0] b,
                                            input logic       fopen,
                                            input logic [3:0] pcnt);
    tok_res_t   r;
    logic [7:0] up;
    up = ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ? (b & ~CASE_BIT) : b;
    r.emit         = 1'b0;
    r.kind         = KIND_PREFIX;
    r.obyte        = b;
    r.start        = 1'b0;
    r.pnum         = 4'd0;
    r.phase        = phase;
    r.field_open   = fopen;
    r.param_cnt    = pcnt;
    r.set_prefix   = 1'b0;
    r.set_trailing = 1'b0;
    case (phase)
      PH_LEAD: begin
        if (!irc_is_ws(b)) begin
          if (b == CH_COLON) begin
            r.set_prefix = 1'b1;
            r.field_open = 1'b0;
            r.phase      = PH_PREFIX;
          end else begin
            r.emit  = 1'b1;
            r.kind  = KIND_COMMAND;
            r.obyte = up;
            r.start = 1'b1;
            r.phase = PH_COMMAND;
          end
        end
      end
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          r.phase = PH_PRE_GAP;
        end else begin
          r.emit       = 1'b1;
          r.kind       = KIND_PREFIX;
          r.start      = ~fopen;
          r.field_open = 1'b1;
        end
      end
      PH_PRE_GAP: begin
        if (b != CH_SPACE) begin
          r.emit  = 1'b1;
          r.kind  = KIND_COMMAND;
          r.obyte = up;
          r.start = 1'b1;
          r.phase = PH_COMMAND;
        end
      end
      PH_COMMAND: begin
        if (b == CH_SPACE) begin
          r.phase = PH_PARAM_GAP;
        end else begin
          r.emit  = 1'b1;
          r.kind  = KIND_COMMAND;
          r.obyte = up;
        end
      end
      PH_PARAM_GAP: begin
        if (b == CH_COLON) begin
          r.set_trailing = 1'b1;
          r.field_open   = 1'b0;
          r.phase        = PH_TRAILING;
        end else if (b != CH_SPACE) begin
          r.emit      = 1'b1;
          r.kind      = KIND_PARAM;
          r.start     = 1'b1;
          r.pnum      = pcnt;
          r.param_cnt = (pcnt == PARAM_MAX) ? pcnt : pcnt + 4'd1;
          r.phase     = PH_PARAM;
        end
      end
      PH_PARAM: begin
        if (b == CH_SPACE) begin
          r.phase = PH_PARAM_GAP;
        end else begin
          r.emit = 1'b1;
          r.kind = KIND_PARAM;
          r.pnum = (pcnt == 4'd0) ? 4'd0 : pcnt - 4'd1;
        end
      end
      default: begin
        r.emit       = 1'b1;
        r.kind       = KIND_TRAILING;
        r.start      = ~fopen;
        r.field_open = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

[design/irc_front.sv]
// Front end: accepts input items, tags whitespace, and queues them for the back end.
// Depends on irc_pkg and the assertion macros in irc_line_tokenizer_defines.svh.
`timescale 1ns / 1ps
`include "irc_line_tokenizer_defines.svh"

module irc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  irc_pkg::irc_in_t in_data,
  output logic            q_valid,
  output irc_pkg::irc_q_t q_head,
  input  logic            q_pop
);
  import irc_pkg::*;

  localparam int QAW = $clog2(IRC_QDEPTH);

  irc_q_t         q_mem_r [IRC_QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push;
  irc_q_t         entry;

  assign in_stall = (cnt_r == IRC_QDEPTH[QAW:0]);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_mem_r[rd_ptr_r];

  always_comb begin
    entry.line_byte = in_data.line_byte;
    entry.line_end  = in_data.line_end;
    entry.is_ws     = irc_is_ws(in_data.line_byte);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  `IRC_ASSERT_NOW(a_q_bound, 1'b1, cnt_r <= IRC_QDEPTH[QAW:0], "queue count above depth")
  `IRC_ASSERT_NOW(a_q_pop_nonempty, q_pop, cnt_r != '0, "pop from empty queue")

endmodule

[design/irc_back.sv]
// Back end: runs the tokenizer phase machine, holds whitespace runs, emits result items.
// Depends on irc_pkg and the assertion macros in irc_line_tokenizer_defines.svh.
`timescale 1ns / 1ps
`include "irc_line_tokenizer_defines.svh"

module irc_back #(
  parameter int WS_DEPTH = irc_pkg::IRC_WS_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  irc_pkg::irc_q_t  q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output irc_pkg::irc_out_t out_data
);
  import irc_pkg::*;

  localparam int AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
  localparam int CW = $clog2(WS_DEPTH + 1);
  localparam logic [CW-1:0] HOLD_FULL = WS_DEPTH[CW-1:0];

  bk_state_t     state_r, state_nxt;
  irc_phase_t    phase_r, phase_nxt;
  logic [CW-1:0] held_cnt_r, held_cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [3:0]    param_cnt_r, param_cnt_nxt;
  logic          field_open_r, field_open_nxt;
  logic          prefix_r, prefix_nxt;
  logic          trailing_r, trailing_nxt;
  logic          overflow_r, overflow_nxt;
  logic          out_valid_r, out_valid_nxt;
  irc_out_t      out_data_r, out_data_nxt;
  irc_q_t        cur_r;

  logic [7:0]    mem_r [WS_DEPTH];
  logic [7:0]    rd_data_r;
  logic          hold_we;

  logic          out_free;
  logic          direct_path;
  logic          hold_path;
  logic          go;
  logic [7:0]    tok_byte;
  tok_res_t      tok;
  logic [1:0]    status;
  logic          replay_done;

  assign out_free    = !out_valid_r || !out_stall;
  // Bytes in the leading phase, and kept bytes with nothing held, go straight through.
  assign direct_path = (phase_r == PH_LEAD) || (!q_head.is_ws && (held_cnt_r == '0));
  assign hold_path   = (phase_r != PH_LEAD) && q_head.is_ws;
  assign replay_done = ((idx_r + 1'b1) == held_cnt_r);

  always_comb begin
    case (state_r)
      BK_REPLAY: tok_byte = rd_data_r;
      BK_BYTE:   tok_byte = cur_r.line_byte;
      default:   tok_byte = q_head.line_byte;
    endcase
  end

  assign tok = irc_tokenize(phase_r, tok_byte, field_open_r, param_cnt_r);

  always_comb begin
    if (overflow_r) begin
      status = ST_WS_OVFL;
    end else if (phase_r == PH_LEAD) begin
      status = ST_EMPTY;
    end else if ((phase_r == PH_PREFIX) || (phase_r == PH_PRE_GAP)) begin
      status = ST_NO_CMD;
    end else begin
      status = ST_OK;
    end
  end

  // Whether the current state makes its step this cycle.
  always_comb begin
    case (state_r)
      BK_IDLE: begin
        go = q_valid && (!direct_path || !tok.emit || out_free);
      end
      BK_RD:     go = 1'b1;
      BK_REPLAY: go = !tok.emit || out_free;
      BK_BYTE:   go = !tok.emit || out_free;
      BK_STATUS: go = out_free;
      default:   go = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (go) begin
      case (state_r)
        BK_IDLE: begin
          if (direct_path || hold_path) begin
            state_nxt = q_head.line_end ? BK_STATUS : BK_IDLE;
          end else begin
            state_nxt = BK_RD;
          end
        end
        BK_RD:     state_nxt = BK_REPLAY;
        BK_REPLAY: state_nxt = replay_done ? BK_BYTE : BK_RD;
        BK_BYTE:   state_nxt = cur_r.line_end ? BK_STATUS : BK_IDLE;
        BK_STATUS: state_nxt = BK_IDLE;
        default:   state_nxt = BK_IDLE;
      endcase
    end
  end

  // Datapath and outputs.
  always_comb begin
    q_pop          = 1'b0;
    hold_we        = 1'b0;
    phase_nxt      = phase_r;
    held_cnt_nxt   = held_cnt_r;
    idx_nxt        = idx_r;
    param_cnt_nxt  = param_cnt_r;
    field_open_nxt = field_open_r;
    prefix_nxt     = prefix_r;
    trailing_nxt   = trailing_r;
    overflow_nxt   = overflow_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    if (go) begin
      case (state_r)
        BK_IDLE: begin
          q_pop = 1'b1;
          if (hold_path && !direct_path) begin
            if (held_cnt_r < HOLD_FULL) begin
              hold_we      = 1'b1;
              held_cnt_nxt = held_cnt_r + 1'b1;
            end else begin
              overflow_nxt = 1'b1;
            end
          end else if (!direct_path) begin
            idx_nxt = '0;
          end
        end
        BK_REPLAY: begin
          idx_nxt = idx_r + 1'b1;
          if (replay_done) begin
            held_cnt_nxt = '0;
          end
        end
        BK_STATUS: begin
          out_valid_nxt              = 1'b1;
          out_data_nxt               = '0;
          out_data_nxt.field_kind    = KIND_STATUS;
          out_data_nxt.line_status   = status;
          out_data_nxt.prefix_seen   = prefix_r;
          out_data_nxt.trailing_seen = trailing_r;
          out_data_nxt.param_total   = param_cnt_r;
          out_data_nxt.last_of_line  = 1'b1;
          phase_nxt                  = PH_LEAD;
          held_cnt_nxt               = '0;
          param_cnt_nxt              = '0;
          field_open_nxt             = 1'b0;
          prefix_nxt                 = 1'b0;
          trailing_nxt               = 1'b0;
          overflow_nxt               = 1'b0;
        end
        default: begin
        end
      endcase

      // A tokenizer step happens on direct items, replayed bytes and the releasing byte.
      if (((state_r == BK_IDLE) && direct_path) || (state_r == BK_REPLAY) ||
          (state_r == BK_BYTE)) begin
        phase_nxt      = tok.phase;
        param_cnt_nxt  = tok.param_cnt;
        field_open_nxt = tok.field_open;
        prefix_nxt     = prefix_r | tok.set_prefix;
        trailing_nxt   = trailing_r | tok.set_trailing;
        if (tok.emit) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt              = '0;
          out_data_nxt.field_kind   = tok.kind;
          out_data_nxt.out_byte     = tok.obyte;
          out_data_nxt.field_start  = tok.start;
          out_data_nxt.param_number = tok.pnum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      phase_r      <= PH_LEAD;
      held_cnt_r   <= '0;
      idx_r        <= '0;
      param_cnt_r  <= '0;
      field_open_r <= 1'b0;
      prefix_r     <= 1'b0;
      trailing_r   <= 1'b0;
      overflow_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      held_cnt_r   <= held_cnt_nxt;
      idx_r        <= idx_nxt;
      param_cnt_r  <= param_cnt_nxt;
      field_open_r <= field_open_nxt;
      prefix_r     <= prefix_nxt;
      trailing_r   <= trailing_nxt;
      overflow_r   <= overflow_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  // Held whitespace store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (hold_we) begin
      mem_r[held_cnt_r[AW-1:0]] <= q_head.line_byte;
    end
    rd_data_r <= mem_r[idx_r[AW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IRC_ASSERT_NOW(a_held_bound, 1'b1, held_cnt_r <= HOLD_FULL, "held count above depth")
  `IRC_ASSERT_NOW(a_lead_clean, phase_r == PH_LEAD, held_cnt_r == '0,
                  "whitespace held in leading phase")
  `IRC_ASSERT_NEXT(a_status_resets, go && (state_r == BK_STATUS),
                   (phase_r == PH_LEAD) && (held_cnt_r == '0) && !overflow_r,
                   "line state not cleared after status")

endmodule

[design/irc_line_tokenizer.sv]
// IRC line tokenizer: takes one message byte per item and returns tagged field bytes
// plus one status item per line. An item that ends a held whitespace run makes the back
// end replay each held byte before the item itself is stepped: each held byte is read
// from the whitespace store with a registered read and then passed through the one
// tokenizer step. A line's final item is followed by its status item, and the back end
// takes no new item meanwhile. A four-entry queue between front and back absorbs these bursts.
`timescale 1ns / 1ps

module irc_line_tokenizer #(
  parameter int WS_DEPTH = irc_pkg::IRC_WS_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  irc_pkg::irc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output irc_pkg::irc_out_t out_data
);
  import irc_pkg::*;

  logic   q_valid;
  logic   q_pop;
  irc_q_t q_head;

  irc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  irc_back #(
    .WS_DEPTH (WS_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[verif/irc_line_tokenizer_tb.sv]
// Self-checking testbench for irc_line_tokenizer: drives message bytes with random gaps
// and output stalls, predicts every tagged byte and status item, and compares them.
// Depends on irc_pkg (types and character/kind/status constants) and the tokenizer RTL.
`timescale 1ns / 1ps

module irc_line_tokenizer_tb;
  import irc_pkg::*;

  localparam int HOLD_DEPTH   = IRC_WS_DEPTH;
  localparam int ITEM_TARGET  = 210;
  localparam int LONG_HOLD    = 150;
  localparam int TAIL_CYCLES  = 60;
  localparam int DRAIN_LIMIT  = 50000;

  localparam int SHAPE_PLAIN    = 0;
  localparam int SHAPE_MANY     = 1;
  localparam int SHAPE_OVERFLOW = 2;
  localparam int SHAPE_NOISE    = 3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  irc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  irc_out_t out_data;

  // Tokenizer state as the testbench predicts it.
  irc_phase_t  tok_phase;
  logic [7:0]  held_ws [HOLD_DEPTH];
  int          held_n;
  logic [3:0]  param_cnt;
  logic        field_open;
  logic        saw_prefix;
  logic        saw_trailing;
  logic        ws_overflow;

  irc_out_t    pending_results[$];
  irc_out_t    due_result;
  logic [7:0]  line_buf[$];
  int          err_count;
  int          sent_items;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;

  irc_line_tokenizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bit is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  task automatic push_byte(input logic [2:0] kind, input logic [7:0] b, input logic start,
                           input logic [3:0] pnum);
    irc_out_t r;
    r = '0;
    r.field_kind   = kind;
    r.out_byte     = b;
    r.field_start  = start;
    r.param_number = pnum;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic clear_line_state();
    tok_phase    = PH_LEAD;
    held_n       = 0;
    param_cnt    = 4'd0;
    field_open   = 1'b0;
    saw_prefix   = 1'b0;
    saw_trailing = 1'b0;
    ws_overflow  = 1'b0;
  endtask

  // Advances the field tagger by one byte and queues the byte result, if any.
  task automatic tag_byte(input logic [7:0] b);
    logic [7:0] upper;
    upper = (b >= CH_LOW_A && b <= CH_LOW_Z) ? b - 8'd32 : b;
    case (tok_phase)
      PH_LEAD: begin
        if (!is_blank(b)) begin
          if (b == CH_COLON) begin
            saw_prefix = 1'b1;
            field_open = 1'b0;
            tok_phase  = PH_PREFIX;
          end else begin
            push_byte(KIND_COMMAND, upper, 1'b1, 4'd0);
            tok_phase = PH_COMMAND;
          end
        end
      end
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          tok_phase = PH_PRE_GAP;
        end else begin
          push_byte(KIND_PREFIX, b, !field_open, 4'd0);
          field_open = 1'b1;
        end
      end
      PH_PRE_GAP: begin
        if (b != CH_SPACE) begin
          push_byte(KIND_COMMAND, upper, 1'b1, 4'd0);
          tok_phase = PH_COMMAND;
        end
      end
      PH_COMMAND: begin
        if (b == CH_SPACE) tok_phase = PH_PARAM_GAP;
        else push_byte(KIND_COMMAND, upper, 1'b0, 4'd0);
      end
      PH_PARAM_GAP: begin
        if (b == CH_COLON) begin
          saw_trailing = 1'b1;
          field_open   = 1'b0;
          tok_phase    = PH_TRAILING;
        end else if (b != CH_SPACE) begin
          push_byte(KIND_PARAM, b, 1'b1, param_cnt);
          if (param_cnt != PARAM_MAX) param_cnt = param_cnt + 4'd1;
          tok_phase = PH_PARAM;
        end
      end
      PH_PARAM: begin
        if (b == CH_SPACE) tok_phase = PH_PARAM_GAP;
        else push_byte(KIND_PARAM, b, 1'b0, (param_cnt == 4'd0) ? 4'd0 : param_cnt - 4'd1);
      end
      default: begin
        push_byte(KIND_TRAILING, b, !field_open, 4'd0);
        field_open = 1'b1;
      end
    endcase
  endtask

  task automatic predict_tokens(input logic [7:0] b, input logic last);
    irc_out_t st;
    sent_items++;
    if (tok_phase == PH_LEAD) begin
      tag_byte(b);
    end else if (is_blank(b)) begin
      // Whitespace inside a line waits until a visible byte shows it is not trailing.
      if (held_n < HOLD_DEPTH) begin
        held_ws[held_n] = b;
        held_n++;
      end else begin
        ws_overflow = 1'b1;
      end
    end else begin
      for (int k = 0; k < held_n; k++) tag_byte(held_ws[k]);
      held_n = 0;
      tag_byte(b);
    end
    if (last) begin
      st = '0;
      st.field_kind = KIND_STATUS;
      if (ws_overflow) st.line_status = ST_WS_OVFL;
      else if (tok_phase == PH_LEAD) st.line_status = ST_EMPTY;
      else if (tok_phase inside {PH_PREFIX, PH_PRE_GAP}) st.line_status = ST_NO_CMD;
      else st.line_status = ST_OK;
      st.prefix_seen   = saw_prefix;
      st.trailing_seen = saw_trailing;
      st.param_total   = param_cnt;
      st.last_of_line  = 1'b1;
      pending_results.insert(pending_results.size(), st);
      clear_line_state();
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{line_byte: b, line_end: last};
    do @(posedge clk); while (in_stall);
    predict_tokens(b, last);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_item(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual %h", $time, out_data);
        err_count++;
      end else begin
        due_result = pending_results.pop_front();
        check_field("field_kind", due_result.field_kind, out_data.field_kind);
        check_field("out_byte", due_result.out_byte, out_data.out_byte);
        check_field("field_start", due_result.field_start, out_data.field_start);
        check_field("param_number", due_result.param_number, out_data.param_number);
        check_field("line_status", due_result.line_status, out_data.line_status);
        check_field("prefix_seen", due_result.prefix_seen, out_data.prefix_seen);
        check_field("trailing_seen", due_result.trailing_seen, out_data.trailing_seen);
        check_field("param_total", due_result.param_total, out_data.param_total);
        check_field("last_of_line", due_result.last_of_line, out_data.last_of_line);
      end
    end
  end

  // Output side: a random stall before each item, or one long hold when requested.
  initial begin : rx_side
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = rx_idle ? $urandom_range(0, 12) : 0;
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] token_byte();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 8'd97 + 8'($urandom_range(0, 25));
      4: return 8'd65 + 8'($urandom_range(0, 25));
      5: return 8'd48 + 8'($urandom_range(0, 9));
      6: return 8'($urandom_range(0, 255));
      default: return ($urandom_range(0, 1) == 0) ? CH_COLON : "!";
    endcase
  endfunction

  task automatic add_gap();
    repeat ($urandom_range(1, 3)) line_buf.insert(line_buf.size(), CH_SPACE);
    if ($urandom_range(0, 5) == 0) line_buf.insert(line_buf.size(), blank_byte());
  endtask

  task automatic add_token(input int len);
    repeat (len) line_buf.insert(line_buf.size(), token_byte());
  endtask

  task automatic build_line(input int shape);
    int n_params;
    line_buf = {};
    repeat ($urandom_range(0, 2)) line_buf.insert(line_buf.size(), blank_byte());
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0: line_buf.insert(line_buf.size(), blank_byte());
          1: line_buf.insert(line_buf.size(), CH_COLON);
          default: line_buf.insert(line_buf.size(), 8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        line_buf.insert(line_buf.size(), CH_COLON);
        add_token($urandom_range(0, 4));
        add_gap();
      end
      if ($urandom_range(0, 9) != 0) begin
        add_token($urandom_range(1, 4));
        if (shape == SHAPE_OVERFLOW) begin
          // Sixteen fills the store exactly; more than that overflows it.
          repeat ($urandom_range(HOLD_DEPTH, HOLD_DEPTH + 4))
            line_buf.insert(line_buf.size(), blank_byte());
          add_token(1);
        end
        n_params = (shape == SHAPE_MANY) ? $urandom_range(15, 18) : $urandom_range(0, 4);
        repeat (n_params) begin
          add_gap();
          add_token($urandom_range(1, 3));
        end
        if ($urandom_range(0, 1) == 0) begin
          add_gap();
          line_buf.insert(line_buf.size(), CH_COLON);
          repeat ($urandom_range(0, 6))
            line_buf.insert(line_buf.size(),
                            ($urandom_range(0, 3) == 0) ? blank_byte() : token_byte());
        end
      end
    end
    repeat ($urandom_range(0, 2)) line_buf.insert(line_buf.size(), blank_byte());
    if (line_buf.size() == 0) line_buf.insert(line_buf.size(), blank_byte());
  endtask

  task automatic test_empty_lines();
    line_buf = '{CH_SPACE};
    send_line();
    line_buf = '{CH_CR, CH_LF};
    send_line();
  endtask

  task automatic test_prefix_cases();
    // Empty prefix followed by a lower-case command, then a prefix with no command.
    line_buf = '{CH_COLON, CH_SPACE, "q"};
    send_line();
    line_buf = '{CH_COLON, "p"};
    send_line();
  endtask

  task automatic test_separators();
    // A tab inside the command is part of it; the colon opens an empty trailing field.
    line_buf = '{"a", CH_TAB, "z", CH_SPACE, CH_SPACE, CH_COLON};
    send_line();
    line_buf = '{"c", CH_SPACE, CH_SPACE, "p"};
    send_line();
  endtask

  task automatic test_byte_extremes();
    // The final carriage return is held and then trimmed at the end of the line.
    line_buf = '{8'hFF, CH_SPACE, 8'h00, CH_SPACE, "x", CH_CR};
    send_line();
  endtask

  task automatic test_back_pressure();
    hold_req = 1'b1;
    tx_idle  = 1'b0;
    line_buf = '{"p", "i", "n", "g", CH_SPACE};
    repeat (35) line_buf.insert(line_buf.size(), token_byte() | 8'h80);
    send_line();
  endtask

  task automatic test_random_lines();
    int line_no;
    int shape;
    line_no = 0;
    while (sent_items < ITEM_TARGET) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (line_no == 3) shape = SHAPE_MANY;
      else if (line_no == 5 || line_no == 9) shape = SHAPE_OVERFLOW;
      else if ($urandom_range(0, 5) == 0) shape = SHAPE_NOISE;
      else if ($urandom_range(0, 11) == 0) shape = SHAPE_OVERFLOW;
      else shape = SHAPE_PLAIN;
      build_line(shape);
      send_line();
      line_no++;
    end
  endtask

  initial begin : run_tests
    int waited;
    err_count  = 0;
    sent_items = 0;
    hold_req   = 1'b0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    clear_line_state();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_lines();
    test_prefix_cases();
    test_separators();
    test_byte_extremes();
    test_back_pressure();
    test_random_lines();
    in_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: missing items: expected %0d more, actual 0", $time,
               pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
